[src/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies; included by bare name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, skipped while reset is asserted.
`define AST_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define AST_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bqfs_pkg.sv]
// Shared types, codes and helpers for the bounded queue server.
// No dependencies; used by every module of the block but the tag store.
package bqfs_pkg;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 224;
    localparam int M_TUSER_W = 2;
    localparam int CFG_AW    = 1;
    localparam int CFG_DW    = 24;
    localparam int LIMIT_W   = 11;
    localparam int SVC_W     = 24;
    localparam int OCC_W     = 11;
    localparam int SUM_W     = 48;

    // input word kinds
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_ARRIVAL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_QUEUE_LIMIT  = 1'b0;
    localparam logic [CFG_AW-1:0] REG_SERVICE_TIME = 1'b1;

    // per-word events handed to the statistics counters
    typedef struct packed {
        logic fire;
        logic is_tick;
        logic idle;
        logic arrival;
        logic drop;
    } stat_evt_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

[src/bqfs_store.sv]
// Packet tag store: one write port, one read port, registered read data.
// A read of the entry written on the same edge returns the new tag.
module bqfs_store #(
    parameter int DEPTH     = 1024,
    parameter int TAG_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [TAG_WIDTH-1:0]     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [TAG_WIDTH-1:0]     rdata
);

    logic [TAG_WIDTH-1:0] mem [DEPTH];
    logic [TAG_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bqfs_stats.sv]
// Saturating drop, arrival, idle and occupancy-sum counters.
// Depends on bqfs_pkg for the event struct and the increment helper.
module bqfs_stats #(
    parameter int CW = 11
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bqfs_pkg::stat_evt_t     evt,
    input  logic [CW-1:0]           count,
    output logic [31:0]             drops_next,
    output logic [31:0]             arrivals_next,
    output logic [31:0]             idles_next,
    output logic [bqfs_pkg::SUM_W-1:0] occ_next
);

    localparam int SW = bqfs_pkg::SUM_W;

    logic [31:0]   drops_reg;
    logic [31:0]   arrivals_reg;
    logic [31:0]   idles_reg;
    logic [SW-1:0] occ_reg;
    logic [SW:0]   occ_sum;

    always_comb begin
        occ_sum       = {1'b0, occ_reg} + (SW+1)'(count);
        drops_next    = (evt.fire && evt.drop) ? bqfs_pkg::sat_inc32(drops_reg) : drops_reg;
        arrivals_next = (evt.fire && evt.arrival) ?
                        bqfs_pkg::sat_inc32(arrivals_reg) : arrivals_reg;
        idles_next    = (evt.fire && evt.idle) ? bqfs_pkg::sat_inc32(idles_reg) : idles_reg;
        occ_next      = occ_reg;
        if (evt.fire && evt.is_tick) begin
            occ_next = occ_sum[SW] ? '1 : occ_sum[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drops_reg    <= '0;
            arrivals_reg <= '0;
            idles_reg    <= '0;
            occ_reg      <= '0;
        end else begin
            drops_reg    <= drops_next;
            arrivals_reg <= arrivals_next;
            idles_reg    <= idles_next;
            occ_reg      <= occ_next;
        end
    end

endmodule

[src/bounded_queue_fixed_service_server_top.sv]
// Single server with a bounded FIFO and a fixed service time.
// Depends on bqfs_pkg, bqfs_store and bqfs_stats.
//
// Each input word is a tick (tuser 0) or a packet arrival (tuser 1) and gives
// exactly one output word. A word is taken into an execute stage, the head tag
// is read from the store on that same edge, and the result is registered in the
// output register as the word leaves that stage; a new word can be taken every
// cycle as long as the output register drains. Throughput is then one word per
// cycle, set by the store's single registered read of the head entry, which is
// forwarded from the tail write when a packet is pushed into an empty queue. The
// store needs no clearing after reset: only entries written by an arrival are read.
module bounded_queue_fixed_service_server_top #(
    parameter int DEPTH     = 1024,
    parameter int TAG_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bqfs_pkg::S_TDATA_W-1:0]  s_tdata,   // tick_now, packet_tag
    input  logic [bqfs_pkg::S_TUSER_W-1:0]  s_tuser,   // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // served_tag, done_tick, occupancy, dropped_count, arrival_count,
    // idle_count, occupancy_sum, zero pad
    output logic [bqfs_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [bqfs_pkg::M_TUSER_W-1:0]  m_tuser,   // served, accepted
    input  logic                            cfg_we,
    input  logic [bqfs_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [bqfs_pkg::CFG_DW-1:0]     cfg_wdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int TW_IN = (TAG_WIDTH < 32) ? TAG_WIDTH : 32;
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    // configuration
    logic [bqfs_pkg::LIMIT_W-1:0] queue_limit_reg;
    logic [bqfs_pkg::SVC_W-1:0]   service_time_reg;

    // execute stage
    logic        x_valid_reg;
    logic        x_mode_reg;
    logic [31:0] x_now_reg;
    logic [31:0] x_tag_reg;

    // queue state
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   due_reg, due_next;
    logic [31:0]   last_reg, last_next;

    // output register
    logic                           m_valid_reg;
    logic [bqfs_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [bqfs_pkg::M_TUSER_W-1:0] m_tuser_reg;

    logic                 out_free, fire, take;
    logic                 served, accepted, is_idle, is_drop;
    logic                 store_we;
    logic [AW-1:0]        rd_addr;
    logic [TAG_WIDTH-1:0] rd_tag;
    logic [31:0]          served_tag, done_tick;
    logic [CW-1:0]        eff_limit;
    logic                 limit_full;

    bqfs_pkg::stat_evt_t         evt;
    logic [31:0]                 drops_n, arrivals_n, idles_n;
    logic [bqfs_pkg::SUM_W-1:0]  occ_n;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + AW'(1);
    endfunction

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = x_valid_reg && out_free;
    assign s_tready = !x_valid_reg || out_free;
    assign take     = s_tvalid && s_tready;

    // zero or above the buffer depth means the whole buffer
    assign limit_full = (queue_limit_reg == '0) || (32'(queue_limit_reg) > 32'(DEPTH));
    assign eff_limit  = limit_full ? DEPTH_C : CW'(queue_limit_reg);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        due_next   = due_reg;
        last_next  = last_reg;
        served     = 1'b0;
        accepted   = 1'b0;
        is_idle    = 1'b0;
        is_drop    = 1'b0;
        store_we   = 1'b0;
        unique case (x_mode_reg)
            bqfs_pkg::MODE_TICK: begin
                last_next = x_now_reg;
                if (count_reg != '0) begin
                    if (x_now_reg >= due_reg) begin
                        served     = 1'b1;
                        head_next  = ptr_inc(head_reg);
                        count_next = count_reg - CW'(1);
                        due_next   = (count_next != '0) ?
                                     x_now_reg + 32'(service_time_reg) : 32'd0;
                    end
                end else begin
                    is_idle  = 1'b1;
                    due_next = 32'd0;
                end
            end
            bqfs_pkg::MODE_ARRIVAL: begin
                if (count_reg < eff_limit) begin
                    store_we   = fire;
                    accepted   = 1'b1;
                    tail_next  = ptr_inc(tail_reg);
                    count_next = count_reg + CW'(1);
                    if (due_reg == 32'd0) begin
                        due_next = last_reg + 32'(service_time_reg);
                    end
                end else begin
                    is_drop = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // keep the head entry in the read register for the next word
    assign rd_addr = fire ? head_next : head_reg;

    bqfs_store #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (tail_reg),
        .wdata (TAG_WIDTH'(x_tag_reg[TW_IN-1:0])),
        .raddr (rd_addr),
        .rdata (rd_tag)
    );

    always_comb begin
        evt.fire    = fire;
        evt.is_tick = (x_mode_reg == bqfs_pkg::MODE_TICK);
        evt.idle    = is_idle;
        evt.arrival = (x_mode_reg == bqfs_pkg::MODE_ARRIVAL);
        evt.drop    = is_drop;
    end

    bqfs_stats #(
        .CW (CW)
    ) u_stats (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .evt           (evt),
        .count         (count_reg),
        .drops_next    (drops_n),
        .arrivals_next (arrivals_n),
        .idles_next    (idles_n),
        .occ_next      (occ_n)
    );

    assign served_tag = served ? 32'(rd_tag[TW_IN-1:0]) : 32'd0;
    assign done_tick  = served ? x_now_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_limit_reg  <= '0;
            service_time_reg <= bqfs_pkg::SVC_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bqfs_pkg::REG_QUEUE_LIMIT:
                    queue_limit_reg <= cfg_wdata[bqfs_pkg::LIMIT_W-1:0];
                bqfs_pkg::REG_SERVICE_TIME:
                    service_time_reg <= cfg_wdata[bqfs_pkg::SVC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            due_reg     <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                x_valid_reg <= 1'b1;
            end else if (fire) begin
                x_valid_reg <= 1'b0;
            end
            if (fire) begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                due_reg     <= due_next;
                last_reg    <= last_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            x_mode_reg <= s_tuser[0];
            x_now_reg  <= s_tdata[31:0];
            x_tag_reg  <= s_tdata[63:32];
        end
        if (fire) begin
            m_tdata_reg <= {5'd0, occ_n, idles_n, arrivals_n, drops_n,
                            bqfs_pkg::OCC_W'(count_next), done_tick, served_tag};
            m_tuser_reg <= {accepted, served};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[src/bqfs_checker.sv]
// Port-level checks for the bounded queue server, bound to the top level.
// Depends on bqfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bqfs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bqfs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [bqfs_pkg::M_TUSER_W-1:0] m_tuser
);

    // a stalled result word holds
    `AST_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // a word never both serves a packet and accepts one
    `AST_RST(a_serve_xor_accept, aclk, aresetn, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "served and accepted in one word")

    // tag and end tick read zero when nothing was served
    `AST_RST(a_unserved_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata[63:0] == 64'd0, "served fields nonzero without service")

    // reset empties the output register
    `AST_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind bounded_queue_fixed_service_server_top bqfs_checker u_bqfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[dv/tb_bounded_queue_fixed_service_server_top.sv]
// Self-checking bench for bounded_queue_fixed_service_server_top: directed rows, then
// random tick/arrival traffic over several queue limits and service times.
// Depends on bqfs_pkg and the RTL of the block; results are checked against a local model.
module tb_bounded_queue_fixed_service_server_top;

    localparam int QDEPTH       = 1024;
    localparam int SETTLE_CYC   = 8;
    localparam int LONG_HOLD    = 300;
    localparam int N_DIRECTED   = 20;
    localparam int N_PHASES     = 5;

    typedef struct packed {
        logic        served;
        logic        accepted;
        logic [31:0] served_tag;
        logic [31:0] done_tick;
        logic [10:0] occupancy;
        logic [31:0] dropped_count;
        logic [31:0] arrival_count;
        logic [31:0] idle_count;
        logic [47:0] occupancy_sum;
    } server_out_t;

    typedef struct {
        logic        mode;
        logic [31:0] tick;
        logic [31:0] tag;
        bit          typed;
        server_out_t want;
    } stim_row_t;

    typedef struct {
        int          limit;
        int          svc;
        int          items;
        int          arrival_pct;
        int          send_idle;
        int          recv_stall;
        bit          pressure;
    } phase_t;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [bqfs_pkg::S_TDATA_W-1:0]   s_tdata   = '0;    // tick_now, packet_tag
    logic [bqfs_pkg::S_TUSER_W-1:0]   s_tuser   = '0;    // mode
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    // served_tag, done_tick, occupancy, drops, arrivals, idles, occupancy_sum, pad
    logic [bqfs_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [bqfs_pkg::M_TUSER_W-1:0]   m_tuser;           // served, accepted
    logic                             cfg_we    = 1'b0;
    logic [bqfs_pkg::CFG_AW-1:0]      cfg_addr  = '0;
    logic [bqfs_pkg::CFG_DW-1:0]      cfg_wdata = '0;

    bounded_queue_fixed_service_server_top #(
        .DEPTH     (QDEPTH),
        .TAG_WIDTH (32)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // server model state
    logic [31:0] tag_ram [0:QDEPTH-1];
    logic [9:0]  head_idx;
    logic [9:0]  tail_idx;
    logic [10:0] held;
    logic [31:0] due_at;
    logic [31:0] latest_tick;
    logic [31:0] drop_total;
    logic [31:0] arrival_total;
    logic [31:0] idle_total;
    logic [47:0] occ_sum;
    logic [10:0] limit_reg;
    logic [23:0] svc_reg;

    server_out_t pending_results[$];
    int          failures      = 0;
    int          words_checked = 0;
    int          n_ticks       = 0;
    int          n_arrivals    = 0;
    int          n_served      = 0;
    int          n_drops       = 0;
    int          peak_held     = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        pressure_req  = 1'b0;
    logic        pressure_seen = 1'b0;
    int          stall_left    = 0;
    logic [31:0] clock_now     = '0;

    stim_row_t   directed_rows [0:N_DIRECTED-1];
    phase_t      phases        [0:N_PHASES-1];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(20 * 400000);
        $display("bounded_queue_fixed_service_server_top test failed");
        $finish;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return v + {31'd0, (v != 32'hFFFF_FFFF)};
    endfunction

    // One step of the server: updates the local state, returns the word it emits.
    function automatic server_out_t advance_server(input logic mode, input logic [31:0] now,
                                                   input logic [31:0] tag);
        server_out_t r;
        logic [48:0] sum_next;
        int          cap;
        r = '0;
        if (mode == bqfs_pkg::MODE_TICK) begin
            latest_tick = now;
            sum_next = {1'b0, occ_sum} + {38'd0, held};
            occ_sum = sum_next[48] ? 48'hFFFF_FFFF_FFFF : sum_next[47:0];
            if (held != 0) begin
                if (now >= due_at) begin
                    r.served     = 1'b1;
                    r.served_tag = tag_ram[head_idx];
                    r.done_tick  = now;
                    head_idx     = head_idx + 10'd1;
                    held         = held - 11'd1;
                    due_at       = (held != 0) ? latest_tick + {8'd0, svc_reg} : 32'd0;
                end
            end else begin
                idle_total = bump(idle_total);
                due_at     = '0;
            end
        end else begin
            arrival_total = bump(arrival_total);
            cap = (limit_reg == 0 || limit_reg > QDEPTH) ? QDEPTH : int'(limit_reg);
            if (int'(held) < cap) begin
                tag_ram[tail_idx] = tag;
                tail_idx   = tail_idx + 10'd1;
                held       = held + 11'd1;
                r.accepted = 1'b1;
                // a sum that wraps to zero leaves the timer unarmed
                if (due_at == 0)
                    due_at = latest_tick + {8'd0, svc_reg};
            end else begin
                drop_total = bump(drop_total);
            end
        end
        r.occupancy     = held;
        r.dropped_count = drop_total;
        r.arrival_count = arrival_total;
        r.idle_count    = idle_total;
        r.occupancy_sum = occ_sum;
        return r;
    endfunction

    task automatic compare_field(input string fname, input logic [47:0] want,
                                 input logic [47:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    // output side: check accepted words, pick the next tready
    always @(posedge aclk) begin
        server_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_checked++;
            if (pending_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result word, expected none, got %0h", $time, m_tdata);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                compare_field("served",        want.served,        m_tuser[0]);
                compare_field("accepted",      want.accepted,      m_tuser[1]);
                compare_field("served_tag",    want.served_tag,    m_tdata[31:0]);
                compare_field("done_tick",     want.done_tick,     m_tdata[63:32]);
                compare_field("occupancy",     want.occupancy,     m_tdata[74:64]);
                compare_field("dropped_count", want.dropped_count, m_tdata[106:75]);
                compare_field("arrival_count", want.arrival_count, m_tdata[138:107]);
                compare_field("idle_count",    want.idle_count,    m_tdata[170:139]);
                compare_field("occupancy_sum", want.occupancy_sum, m_tdata[218:171]);
            end
        end
        if (pressure_req != pressure_seen) begin
            pressure_seen <= pressure_req;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word, wait for the handshake, record what the block must return.
    task automatic offer_word(input logic mode, input logic [31:0] tick, input logic [31:0] tag,
                              input bit typed, input server_out_t want);
        server_out_t r;
        server_out_t queued;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, tick};
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = advance_server(mode, tick, tag);
        queued = typed ? want : r;
        pending_results = {pending_results, queued};
        if (mode == bqfs_pkg::MODE_TICK) n_ticks++;
        else n_arrivals++;
        if (r.served) n_served++;
        if (mode == bqfs_pkg::MODE_ARRIVAL && !r.accepted) n_drops++;
        if (int'(held) > peak_held) peak_held = int'(held);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic program_server(input int limit, input int svc);
        cfg_we    <= 1'b1;
        cfg_addr  <= bqfs_pkg::REG_QUEUE_LIMIT;
        cfg_wdata <= limit[bqfs_pkg::CFG_DW-1:0];
        @(posedge aclk);
        cfg_addr  <= bqfs_pkg::REG_SERVICE_TIME;
        cfg_wdata <= svc[bqfs_pkg::CFG_DW-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_reg = limit[10:0];
        svc_reg   = svc[23:0];
    endtask

    initial begin
        phase_t      ph;
        logic        mode;
        logic [31:0] tick;
        logic [31:0] tag;

        head_idx = '0; tail_idx = '0; held = '0; due_at = '0; latest_tick = '0;
        drop_total = '0; arrival_total = '0; idle_total = '0; occ_sum = '0;
        limit_reg = '0; svc_reg = 24'd1;

        // reset values: queue limit 0 (full depth), service time 1
        //                 mode                    tick           tag            typed
        //                 served acc tag end occ drops arrivals idles sum
        directed_rows = '{
            '{bqfs_pkg::MODE_TICK,    32'd0,         32'h0,         1'b1,
              '{1'b0, 1'b0, 32'h0, 32'h0, 11'd0, 32'd0, 32'd0, 32'd1, 48'd0}},
            '{bqfs_pkg::MODE_ARRIVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{1'b0, 1'b1, 32'h0, 32'h0, 11'd1, 32'd0, 32'd1, 32'd1, 48'd0}},
            '{bqfs_pkg::MODE_ARRIVAL, 32'h0,         32'h0,         1'b1,
              '{1'b0, 1'b1, 32'h0, 32'h0, 11'd2, 32'd0, 32'd2, 32'd1, 48'd0}},
            '{bqfs_pkg::MODE_TICK,    32'd0,         32'h0,         1'b1,
              '{1'b0, 1'b0, 32'h0, 32'h0, 11'd2, 32'd0, 32'd2, 32'd1, 48'd2}},
            '{bqfs_pkg::MODE_TICK,    32'd1,         32'hFFFF_FFFF, 1'b1,
              '{1'b1, 1'b0, 32'hFFFF_FFFF, 32'd1, 11'd1, 32'd0, 32'd2, 32'd1, 48'd4}},
            '{bqfs_pkg::MODE_TICK,    32'hFFFF_FFFF, 32'h0,         1'b1,
              '{1'b1, 1'b0, 32'h0, 32'hFFFF_FFFF, 11'd0, 32'd0, 32'd2, 32'd1, 48'd5}},
            '{bqfs_pkg::MODE_TICK,    32'hFFFF_FFFF, 32'h0,         1'b1,
              '{1'b0, 1'b0, 32'h0, 32'h0, 11'd0, 32'd0, 32'd2, 32'd2, 48'd5}},
            // due tick wraps to zero here: stays unarmed, next tick serves at once
            '{bqfs_pkg::MODE_ARRIVAL, 32'h0,         32'h1234_5678, 1'b1,
              '{1'b0, 1'b1, 32'h0, 32'h0, 11'd1, 32'd0, 32'd3, 32'd2, 48'd5}},
            '{bqfs_pkg::MODE_ARRIVAL, 32'h0,         32'h9ABC_DEF0, 1'b1,
              '{1'b0, 1'b1, 32'h0, 32'h0, 11'd2, 32'd0, 32'd4, 32'd2, 48'd5}},
            '{bqfs_pkg::MODE_TICK,    32'd3,         32'h0,         1'b1,
              '{1'b1, 1'b0, 32'h1234_5678, 32'd3, 11'd1, 32'd0, 32'd4, 32'd2, 48'd7}},
            '{bqfs_pkg::MODE_TICK,    32'd3,         32'h0,         1'b1,
              '{1'b0, 1'b0, 32'h0, 32'h0, 11'd1, 32'd0, 32'd4, 32'd2, 48'd8}},
            '{bqfs_pkg::MODE_TICK,    32'd4,         32'h0,         1'b1,
              '{1'b1, 1'b0, 32'h9ABC_DEF0, 32'd4, 11'd0, 32'd0, 32'd4, 32'd2, 48'd9}},
            '{bqfs_pkg::MODE_ARRIVAL, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
            '{bqfs_pkg::MODE_ARRIVAL, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
            '{bqfs_pkg::MODE_TICK,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
            '{bqfs_pkg::MODE_TICK,    32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
            '{bqfs_pkg::MODE_TICK,    32'h0,         32'hFFFF_FFFF, 1'b0, '0},
            '{bqfs_pkg::MODE_ARRIVAL, 32'h0,         32'hFFFF_0000, 1'b0, '0},
            '{bqfs_pkg::MODE_TICK,    32'd2,         32'h0,         1'b0, '0},
            '{bqfs_pkg::MODE_ARRIVAL, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0, '0}
        };

        //            limit  svc       items arr% sidle rstall pressure
        phases = '{
            '{3,     1,        150,  55,  0,    0,    1'b0},
            '{1,     0,        110,  50,  47,   0,    1'b0},
            '{1024,  2,        110,  60,  25,   25,   1'b1},
            '{0,     5,        110,  45,  0,    47,   1'b0},
            // over-range limit means full depth; long service lets the queue fill
            '{2047,  16777215, 1150, 95,  0,    47,   1'b0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            offer_word(directed_rows[i].mode, directed_rows[i].tick, directed_rows[i].tag,
                       directed_rows[i].typed, directed_rows[i].want);
        s_tvalid <= 1'b0;
        clock_now = 32'd2;

        for (int p = 0; p < N_PHASES; p++) begin
            ph = phases[p];
            wait_drained();
            program_server(ph.limit, ph.svc);
            send_idle_pct  = ph.send_idle;
            recv_stall_pct = ph.recv_stall;
            for (int n = 0; n < ph.items; n++) begin
                if (ph.pressure && n == 20)
                    pressure_req <= ~pressure_req;
                tag = $urandom;
                if ($urandom_range(99) < ph.arrival_pct) begin
                    mode = bqfs_pkg::MODE_ARRIVAL;
                    tick = $urandom;
                end else begin
                    mode = bqfs_pkg::MODE_TICK;
                    // mostly a steady clock, now and then a jump anywhere
                    if ($urandom_range(15) == 0)
                        clock_now = $urandom;
                    else
                        clock_now = clock_now + $urandom_range(3);
                    tick = clock_now;
                end
                offer_word(mode, tick, tag, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        $display("covered %0d ticks and %0d arrivals, %0d words checked", n_ticks, n_arrivals,
                 words_checked);
        $display("served %0d packets, dropped %0d, peak occupancy %0d", n_served, n_drops,
                 peak_held);
        if (failures == 0)
            $display("bounded_queue_fixed_service_server_top test passed");
        else
            $display("bounded_queue_fixed_service_server_top test failed");
        $finish;
    end

endmodule
